FILE: rtl/spsg_pkg.sv
`default_nettype none

package spsg_pkg;

   typedef enum logic [2:0] {
      CMD_TICK       = 3'd0,
      CMD_SET_TARGET = 3'd1,
      CMD_SET_POS    = 3'd2,
      CMD_START      = 3'd3,
      CMD_STOP       = 3'd4,
      CMD_HOME       = 3'd5,
      CMD_JOG        = 3'd6
   } command_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] position_value;
      logic [4:0]  speed_code;
      logic        set_speed;
      logic        jog_backward;
   } req_item_type;

   typedef struct packed {
      logic [3:0]  coil_pattern;
      logic [15:0] position_now;
      logic [15:0] target_now;
      logic        running;
      logic        stepped;
   } rsp_item_type;

   localparam logic [15:0] HOME_RESET  = 16'd20000;
   localparam logic [4:0]  SPEED_RESET = 5'd20;
   localparam logic [2:0]  PHASE_MASK  = 3'h7;

   function automatic logic [3:0] coil_for_phase(input logic [2:0] phase);
      logic [3:0] coils;
      case (phase & PHASE_MASK)
         3'd0:    coils = 4'b1001;
         3'd1:    coils = 4'b0001;
         3'd2:    coils = 4'b0011;
         3'd3:    coils = 4'b0010;
         3'd4:    coils = 4'b0110;
         3'd5:    coils = 4'b0100;
         3'd6:    coils = 4'b1100;
         3'd7:    coils = 4'b1000;
         default: coils = 4'b0000;
      endcase
      return coils;
   endfunction

   function automatic logic [6:0] wait_for_speed(input logic [4:0] code);
      logic [6:0] reload;
      case (code)
         5'd2:    reload = 7'd0;
         5'd4:    reload = 7'd8;
         5'd8:    reload = 7'd16;
         5'd10:   reload = 7'd32;
         5'd20:   reload = 7'd64;
         default: reload = 7'd4;
      endcase
      return reload;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/stepper_position_step_generator_unit.sv
// channel   direction  payload         handshake
// req       in         req_item_type   req_valid / req_stall
// rsp       out        rsp_item_type   rsp_valid / rsp_stall
// csr       in         home position   csr_write_enable, no read-back
//
// one item per cycle sustained while rsp_stall is low; rsp_valid follows the req via
// the input register, then state update and result register in one pass
// synchronous active-high reset: position and target at 20000, coils off
// rsp_stall holds the result register; req_stall rises only while both stages are full
`default_nettype none

module stepper_position_step_generator_unit
   import spsg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_write_enable,
   input  wire logic [15:0]  csr_write_data
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   logic [15:0]  home_ff;
   logic         advance;
   rsp_item_type core_result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff <= HOME_RESET;
      end else if (csr_write_enable) begin
         home_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
   end

   spsg_core u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_item_ff),
      .home_value (home_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

FILE: rtl/spsg_core.sv
`default_nettype none

module spsg_core
   import spsg_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   input  wire logic [15:0]  home_value,
   output rsp_item_type      result
);

   logic [15:0] position_ff, position_in;
   logic [15:0] target_ff, target_in;
   logic [2:0]  phase_ff, phase_in;
   logic [6:0]  wait_ff, wait_in;
   logic [4:0]  speed_ff, speed_in;
   logic        run_ff, run_in;
   logic [3:0]  coil_ff, coil_in;
   logic        stepped;
   logic [15:0] diff;
   logic [6:0]  wait_tmp;

   always_comb begin
      position_in = position_ff;
      target_in   = target_ff;
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      speed_in    = speed_ff;
      run_in      = run_ff;
      coil_in     = coil_ff;
      stepped     = 1'b0;
      diff        = target_ff - position_ff;
      wait_tmp    = wait_ff;
      case (item.command)
         CMD_TICK: begin
            if (diff == 16'd0) begin
               run_in = 1'b0;
            end else if (run_ff) begin
               if (wait_ff == 7'd0) begin
                  if (!diff[15]) begin
                     position_in = position_ff + 16'd1;
                     phase_in    = phase_ff + 3'd1;
                  end else begin
                     position_in = position_ff - 16'd1;
                     phase_in    = phase_ff - 3'd1;
                  end
                  coil_in  = coil_for_phase(phase_in);
                  stepped  = 1'b1;
                  wait_tmp = wait_for_speed(speed_ff);
               end
               wait_in = (wait_tmp != 7'd0) ? wait_tmp - 7'd1 : wait_tmp;
            end
         end
         CMD_SET_TARGET: begin
            target_in = item.position_value;
            run_in    = 1'b1;
         end
         CMD_SET_POS: begin
            position_in = item.position_value;
            run_in      = 1'b1;
         end
         CMD_START: begin
            if (item.set_speed) begin
               speed_in = item.speed_code;
            end
            run_in = 1'b1;
         end
         CMD_STOP: begin
            run_in = 1'b0;
         end
         CMD_HOME: begin
            position_in = home_value;
            run_in      = 1'b1;
         end
         CMD_JOG: begin
            speed_in  = item.speed_code;
            target_in = item.jog_backward ? target_ff - 16'd1 : target_ff + 16'd1;
            run_in    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= HOME_RESET;
         target_ff   <= HOME_RESET;
         phase_ff    <= 3'd0;
         wait_ff     <= 7'd0;
         speed_ff    <= SPEED_RESET;
         run_ff      <= 1'b0;
         coil_ff     <= 4'd0;
      end else if (fire) begin
         position_ff <= position_in;
         target_ff   <= target_in;
         phase_ff    <= phase_in;
         wait_ff     <= wait_in;
         speed_ff    <= speed_in;
         run_ff      <= run_in;
         coil_ff     <= coil_in;
      end
   end

   assign result.coil_pattern = coil_in;
   assign result.position_now = position_in;
   assign result.target_now   = target_in;
   assign result.running      = run_in;
   assign result.stepped      = stepped;

endmodule

`default_nettype wire

FILE: rtl/spsg_checker.sv
`default_nettype none

module spsg_checker
   import spsg_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled rsp item changed");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // input only stalls behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stall without a stalled rsp");

   // a step only happens while running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.stepped |-> rsp_item.running)
      else $error("step without running");

   // a step always drives at least one coil
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.stepped |-> rsp_item.coil_pattern != 4'd0)
      else $error("step with coils off");

endmodule

bind stepper_position_step_generator_unit spsg_checker u_spsg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire
